@@ src/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

   // field widths of one word
   localparam int VALUE_W = 32;
   localparam int RANK_W  = 32;
   localparam int OCC_W   = 5;
   localparam int STAT_W  = 2;

   // operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
   localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request word
      logic execute;   // update the cell array and load the result word
   } spq_cmd_type;

endpackage

`default_nettype wire

@@ src/spq_ctrl.sv @@
`default_nettype none

module spq_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output spq_pkg::spq_cmd_type cmd
);
   import spq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // take a word only when no request is pending
   assign req_ready = (state_ff == S_IDLE);

   // execute once the result register is free or is being drained
   always_comb begin
      cmd.capture = req_valid && (state_ff == S_IDLE);
      cmd.execute = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   end

   // advance state and track the result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.execute) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // an accepted word always moves the controller to execute
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted word did not start execution");

   // a new result appears only out of an execute cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.execute))
      else $error("result appeared without execution");

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.execute && rsp_valid_ff && !rsp_ready))
      else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

@@ src/spq_datapath.sv @@
`default_nettype none

module spq_datapath #(
   parameter int CAPACITY = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  spq_pkg::spq_cmd_type             cmd,
   input  wire                              req_opcode,
   input  wire signed [spq_pkg::VALUE_W-1:0] req_entry_value,
   input  wire signed [spq_pkg::RANK_W-1:0]  req_entry_rank,
   output logic       [spq_pkg::STAT_W-1:0]  rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0] rsp_value_out,
   output logic       [spq_pkg::OCC_W-1:0]   rsp_occupancy,
   output logic                             rsp_is_empty
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // request word
   logic                      op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [RANK_W-1:0]  rank_ff;

   // sorted cell array, front entry in cell 0
   logic signed [VALUE_W-1:0] cell_value_ff [CAPACITY];
   logic signed [VALUE_W-1:0] cell_value_in [CAPACITY];
   logic signed [RANK_W-1:0]  cell_rank_ff  [CAPACITY];
   logic signed [RANK_W-1:0]  cell_rank_in  [CAPACITY];
   logic [CNT_W-1:0]          fill_ff, fill_in;

   // result word
   logic [STAT_W-1:0]         status_ff, status_in;
   logic signed [VALUE_W-1:0] vout_ff, vout_in;
   logic [OCC_W-1:0]          occ_ff;
   logic                      empty_ff;

   logic [CAPACITY-1:0] stays;
   logic                is_full, is_empty_now;

   assign is_full      = (fill_ff == CNT_W'(CAPACITY));
   assign is_empty_now = (fill_ff == '0);

   // each occupied cell compares its own rank to the new one
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         stays[i] = (CNT_W'(i) < fill_ff) && (cell_rank_ff[i] <= rank_ff);
      end
   end

   // pick each cell's next word: hold, insert, or shift
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_value_in[i] = cell_value_ff[i];
         cell_rank_in[i]  = cell_rank_ff[i];
      end
      fill_in   = fill_ff;
      vout_in   = '0;
      status_in = ST_ENQUEUED;
      if (op_ff == OP_ENQUEUE) begin
         if (is_full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_ENQUEUED;
            fill_in   = fill_ff + CNT_W'(1);
            // front cell has no neighbor ahead: insert there unless it stays
            if (!stays[0]) begin
               cell_value_in[0] = value_ff;
               cell_rank_in[0]  = rank_ff;
            end
            for (int i = 1; i < CAPACITY; i++) begin
               if (!stays[i]) begin
                  if (stays[i-1]) begin
                     cell_value_in[i] = value_ff;
                     cell_rank_in[i]  = rank_ff;
                  end else begin
                     cell_value_in[i] = cell_value_ff[i-1];
                     cell_rank_in[i]  = cell_rank_ff[i-1];
                  end
               end
            end
         end
      end else begin
         if (is_empty_now) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_DEQUEUED;
            vout_in   = cell_value_ff[0];
            fill_in   = fill_ff - CNT_W'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
               cell_value_in[i] = cell_value_ff[i+1];
               cell_rank_in[i]  = cell_rank_ff[i+1];
            end
         end
      end
   end

   // hold the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.execute) begin
         fill_ff <= fill_in;
      end
   end

   // latch the request, update cells and load the result word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         value_ff <= req_entry_value;
         rank_ff  <= req_entry_rank;
      end
      if (cmd.execute) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cell_value_ff[i] <= cell_value_in[i];
            cell_rank_ff[i]  <= cell_rank_in[i];
         end
         status_ff <= status_in;
         vout_ff   <= vout_in;
         occ_ff    <= OCC_W'(fill_in);
         empty_ff  <= (fill_in == '0);
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_occupancy = occ_ff;
   assign rsp_is_empty  = empty_ff;

`ifndef SYNTHESIS
   // the count never passes the capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // a successful enqueue grows the count by one
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && op_ff == OP_ENQUEUE && !is_full)
      |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("enqueue did not grow the count");

   // the two front cells stay in priority order
   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (fill_ff >= CNT_W'(2)) |-> (cell_rank_ff[0] <= cell_rank_ff[1]))
      else $error("front cells out of order");
`endif

endmodule

`default_nettype wire

@@ src/stable_priority_queue.sv @@
`default_nettype none

// Bounded priority queue of CAPACITY entries: a smaller rank leaves first,
// equal ranks leave in arrival order. Each request word is an enqueue or a
// dequeue and yields exactly one response word with status, dequeued data,
// the occupancy after the request and an empty flag. An enqueue into a full
// queue returns the full status and is dropped; a dequeue from an empty
// queue returns the empty status; neither changes the stored entries.
// Entries sit sorted in a row of cells, and every cell compares its rank to
// the incoming one in parallel. An accepted request has its word latched,
// then updates the cell array and loads the response register.
// Only one request is held at a time: no new word is taken until the
// previous one has updated the cells. A new request is taken while the
// previous response still waits; its update stalls until that response
// is drained.
module stable_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_opcode,
   input  wire signed [spq_pkg::VALUE_W-1:0]   req_entry_value,
   input  wire signed [spq_pkg::RANK_W-1:0]    req_entry_rank,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic       [spq_pkg::STAT_W-1:0]    rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic       [spq_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic                               rsp_is_empty
);
   import spq_pkg::*;

   spq_cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_entry_value (req_entry_value),
      .req_entry_rank  (req_entry_rank),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

`default_nettype wire
